[sv/tgarle_pkg.sv]
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants for the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tgarle_pkg;

  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned CfgIndexWidth = 1;

  localparam logic [CfgIndexWidth-1:0] CFG_TOTAL_PIXELS = 1'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_HAS_ALPHA    = 1'd1;

  localparam logic [31:0] TOTAL_PIXELS_RESET = 32'd1;

  localparam logic [7:0] RUN_FLAG   = 8'h80;
  localparam logic [7:0] COUNT_MASK = 8'd127;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_BYTE1  = 3'd1,
    PH_BYTE2  = 3'd2,
    PH_BYTE3  = 3'd3,
    PH_ALPHA  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       image_done;
    logic       overrun;
  } result_t;

endpackage

`default_nettype wire

[sv/tgarle_core.sv]
// ----------------------------------------------------------------------------
// tgarle_core
// Packet parser and pixel counter: consumes one stream byte per accepted beat
// and produces a result when a raw pixel or a run pixel is complete.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_fire,
  input  wire logic [7:0]          stream_byte,
  input  wire logic [31:0]         total_pixels,
  input  wire logic                has_alpha,
  output logic                     res_valid,
  output tgarle_pkg::result_t      res
);
  import tgarle_pkg::*;

  phase_t      byte_phase, byte_phase_next;
  logic        packet_is_run, packet_is_run_next;
  logic [7:0]  pixels_left, pixels_left_next;
  logic [7:0]  byte_one, byte_one_next;
  logic [7:0]  byte_two, byte_two_next;
  logic [7:0]  byte_three, byte_three_next;
  logic [31:0] pixels_done, pixels_done_next;
  logic        spill, spill_next;

  logic [7:0]  count;
  logic [32:0] sum;
  logic        done;
  logic        over;
  logic        finish;
  logic [7:0]  alpha_byte;
  logic [7:0]  third_byte;
  logic [7:0]  left_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase    <= PH_HEADER;
      packet_is_run <= 1'b0;
      pixels_left   <= '0;
      byte_one      <= '0;
      byte_two      <= '0;
      byte_three    <= '0;
      pixels_done   <= '0;
      spill         <= 1'b0;
    end else if (in_fire) begin
      byte_phase    <= byte_phase_next;
      packet_is_run <= packet_is_run_next;
      pixels_left   <= pixels_left_next;
      byte_one      <= byte_one_next;
      byte_two      <= byte_two_next;
      byte_three    <= byte_three_next;
      pixels_done   <= pixels_done_next;
      spill         <= spill_next;
    end
  end

  always_comb begin
    byte_phase_next    = byte_phase;
    packet_is_run_next = packet_is_run;
    pixels_left_next   = pixels_left;
    byte_one_next      = byte_one;
    byte_two_next      = byte_two;
    byte_three_next    = byte_three;
    pixels_done_next   = pixels_done;
    spill_next         = spill;
    finish             = 1'b0;
    alpha_byte         = 8'd0;
    third_byte         = byte_three;

    unique case (byte_phase)
      PH_BYTE1: begin
        byte_one_next   = stream_byte;
        byte_phase_next = PH_BYTE2;
      end
      PH_BYTE2: begin
        byte_two_next   = stream_byte;
        byte_phase_next = PH_BYTE3;
      end
      PH_BYTE3: begin
        byte_three_next = stream_byte;
        third_byte      = stream_byte;
        if (has_alpha) begin
          byte_phase_next = PH_ALPHA;
        end else begin
          finish = 1'b1;
        end
      end
      PH_ALPHA: begin
        finish     = 1'b1;
        alpha_byte = stream_byte;
      end
      default: begin
        // header beat, also taken for phase codes that cannot arise
        packet_is_run_next = (stream_byte & RUN_FLAG) != 8'd0;
        pixels_left_next   = (stream_byte & COUNT_MASK) + 8'd1;
        spill_next         = 1'b0;
        byte_phase_next    = PH_BYTE1;
      end
    endcase

    count    = packet_is_run ? pixels_left : 8'd1;
    sum      = {1'b0, pixels_done} + {25'd0, count};
    done     = 1'b0;
    over     = 1'b0;
    left_dec = pixels_left - 8'd1;

    if (finish) begin
      if (spill) begin
        over = 1'b1;
      end else if (sum >= {1'b0, total_pixels}) begin
        done             = 1'b1;
        over             = sum > {1'b0, total_pixels};
        pixels_done_next = '0;
      end else begin
        pixels_done_next = sum[31:0];
      end

      if (packet_is_run) begin
        pixels_left_next = '0;
        byte_phase_next  = PH_HEADER;
      end else begin
        pixels_left_next = left_dec;
        if (left_dec == 8'd0) begin
          byte_phase_next = PH_HEADER;
          spill_next      = 1'b0;
        end else begin
          byte_phase_next = PH_BYTE1;
          // rest of this raw packet lies past the finished image
          if (done) begin
            spill_next = 1'b1;
          end
        end
      end
    end

    res_valid        = finish;
    res.red          = third_byte;
    res.green        = byte_two;
    res.blue         = byte_one;
    res.alpha        = alpha_byte;
    res.repeat_count = count;
    res.image_done   = done;
    res.overrun      = over;
  end

endmodule

`default_nettype wire

[sv/tgarle_outbuf.sv]
// ----------------------------------------------------------------------------
// tgarle_outbuf
// Result register with a skid stage, so the input side keeps moving while a
// finished result waits on a stalled receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_outbuf (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire tgarle_pkg::result_t push_data,
  output logic                     full,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output tgarle_pkg::result_t      out_data
);
  import tgarle_pkg::*;

  result_t skid_data;
  logic    skid_valid;
  logic    out_free;

  assign out_free = !out_valid || !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload path, no reset needed
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

[sv/tga_rle_pixel_decoder_top.sv]
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// Run-length decoder for truecolor TGA pixel data, one stream byte per beat.
//
// Input channel: in_valid / in_stall with stream_byte, one compressed byte per
// beat. Output channel: out_valid / out_stall with one beat per finished raw
// pixel or per run, red and blue swapped into place, repeat_count giving the
// run length (1 for raw pixels), plus image_done and overrun flags.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 total_pixels,
// 1 has_alpha); write only while the decoder is idle.
// Throughput is one byte per cycle while in_stall is low. A result is written
// into the result register behind the parser on the beat carrying the last
// byte of its pixel, or into the skid stage while that register is held.
// When the receiver stalls, one more result is held in a skid stage; in_stall
// rises only once that stage is occupied, so bytes keep flowing meanwhile.
// Reset clears the parser to expect a packet header, clears the pixel count,
// empties the output and sets total_pixels to 1 and has_alpha to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [tgarle_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [tgarle_pkg::CfgDataWidth-1:0]  cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [7:0]                           stream_byte,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [7:0]                                red,
  output logic [7:0]                                green,
  output logic [7:0]                                blue,
  output logic [7:0]                                alpha,
  output logic [7:0]                                repeat_count,
  output logic                                      image_done,
  output logic                                      overrun
);
  import tgarle_pkg::*;

  logic [31:0] total_pixels;
  logic        has_alpha;
  logic        in_fire;
  logic        res_valid;
  result_t     res;
  result_t     out_data;
  logic        buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_pixels <= TOTAL_PIXELS_RESET;
      has_alpha    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOTAL_PIXELS: total_pixels <= cfg_data[31:0];
        CFG_HAS_ALPHA:    has_alpha    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = buf_full;
  assign in_fire  = in_valid && !buf_full;

  tgarle_core u_core (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .stream_byte  (stream_byte),
    .total_pixels (total_pixels),
    .has_alpha    (has_alpha),
    .res_valid    (res_valid),
    .res          (res)
  );

  tgarle_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign red          = out_data.red;
  assign green        = out_data.green;
  assign blue         = out_data.blue;
  assign alpha        = out_data.alpha;
  assign repeat_count = out_data.repeat_count;
  assign image_done   = out_data.image_done;
  assign overrun      = out_data.overrun;

endmodule

`default_nettype wire

[tb/tb_tga_rle_pixel_decoder_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tga_rle_pixel_decoder_top
// Self-checking bench for the TGA run-length pixel decoder. A queue of stream
// bytes feeds a clocked driver. A local decoder model turns every accepted
// byte into the pixel beats it should cause. A clocked monitor checks each
// output beat against the oldest pending pixel. The phases change the image
// size, the alpha mode and the idle/stall pressure on both channels.
// ----------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder_top;
  import tgarle_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = CFG_TOTAL_PIXELS;
  logic [CfgDataWidth-1:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  stream_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  red, green, blue, alpha, repeat_count;
  logic        image_done, overrun;

  tga_rle_pixel_decoder_top DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .stream_byte(stream_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .red(red), .green(green), .blue(blue), .alpha(alpha),
    .repeat_count(repeat_count), .image_done(image_done), .overrun(overrun)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // stimulus and pending pixels
  logic [7:0] byte_queue [$];
  result_t    pix_expect [$];

  // register copies and decoder model state
  logic [31:0] cfg_total = TOTAL_PIXELS_RESET;
  logic        cfg_alpha = 1'b0;
  phase_t      dec_phase = PH_HEADER;
  logic        dec_run = 1'b0;
  logic [7:0]  dec_left = 8'd0;
  logic [7:0]  col1 = 8'd0, col2 = 8'd0, col3 = 8'd0;
  logic [31:0] pix_count = 32'd0;
  logic        dec_spill = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_given = 0;
  int unsigned hold_left = 0;
  logic        in_took = 1'b0;

  int unsigned errors = 0;
  int unsigned bytes_taken = 0;
  int unsigned beats_seen = 0;
  int unsigned images_seen = 0;
  int unsigned overruns_seen = 0;
  int unsigned held_cycles = 0;

  task automatic flag_error(input string what);
    errors++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] wanted);
    if (got !== wanted)
      flag_error($sformatf("%s is %0h, should be %0h", name, got, wanted));
  endtask

  task automatic close_pixel(input logic [7:0] alpha_byte);
    result_t     pix;
    logic [32:0] sum;
    logic [7:0]  cnt;
    cnt = dec_run ? dec_left : 8'd1;
    pix.red = col3;
    pix.green = col2;
    pix.blue = col1;
    pix.alpha = alpha_byte;
    pix.repeat_count = cnt;
    pix.image_done = 1'b0;
    pix.overrun = 1'b0;
    if (dec_spill) begin
      pix.overrun = 1'b1;
    end else begin
      sum = {1'b0, pix_count} + cnt;
      if (sum >= {1'b0, cfg_total}) begin
        pix.image_done = 1'b1;
        pix.overrun = (sum > {1'b0, cfg_total});
        pix_count = 32'd0;
      end else begin
        pix_count = sum[31:0];
      end
    end
    pix_expect.push_back(pix);
    if (dec_run) begin
      dec_left = 8'd0;
      dec_phase = PH_HEADER;
    end else begin
      dec_left = dec_left - 8'd1;
      if (dec_left == 8'd0) begin
        dec_phase = PH_HEADER;
        dec_spill = 1'b0;
      end else begin
        dec_phase = PH_BYTE1;
        // rest of a raw packet past the image end
        if (pix.image_done) dec_spill = 1'b1;
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    case (dec_phase)
      PH_BYTE1: begin
        col1 = b;
        dec_phase = PH_BYTE2;
      end
      PH_BYTE2: begin
        col2 = b;
        dec_phase = PH_BYTE3;
      end
      PH_BYTE3: begin
        col3 = b;
        if (cfg_alpha) dec_phase = PH_ALPHA;
        else close_pixel(8'd0);
      end
      PH_ALPHA: begin
        close_pixel(b);
      end
      default: begin
        dec_run = ((b & RUN_FLAG) != 8'd0);
        dec_left = (b & COUNT_MASK) + 8'd1;
        dec_spill = 1'b0;
        dec_phase = PH_BYTE1;
      end
    endcase
  endtask

  // input beat accepted: run the decoder model
  always @(posedge clk) begin
    in_took = in_valid && !in_stall;
    if (!rst && in_took) begin
      decode_byte(stream_byte);
      bytes_taken++;
    end
    if (!rst && in_valid && in_stall) held_cycles++;
  end

  // driver
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (!rst && byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        stream_byte <= byte_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      hold_given <= hold_given + 1;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      beats_seen++;
      if (image_done === 1'b1) images_seen++;
      if (overrun === 1'b1) overruns_seen++;
      if (pix_expect.size() == 0) begin
        flag_error("output beat with no pixel pending");
      end else begin
        want = pix_expect.pop_front();
        check_field("red", red, want.red);
        check_field("green", green, want.green);
        check_field("blue", blue, want.blue);
        check_field("alpha", alpha, want.alpha);
        check_field("repeat_count", repeat_count, want.repeat_count);
        check_field("image_done", {7'd0, image_done}, {7'd0, want.image_done});
        check_field("overrun", {7'd0, overrun}, {7'd0, want.overrun});
      end
    end
  end

  task automatic wait_idle();
    while (byte_queue.size() != 0 || in_valid || pix_expect.size() != 0)
      @(posedge clk);
    // parser may still be mid-packet with nothing pending
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input logic [31:0] total, input logic has_a);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TOTAL_PIXELS;
    cfg_data <= total;
    @(negedge clk);
    cfg_index <= CFG_HAS_ALPHA;
    cfg_data <= {31'd0, has_a};
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_total = total;
    cfg_alpha = has_a;
  endtask

  task automatic queue_random_stream(input int unsigned n_bytes);
    int unsigned added, pix, k, bpp, room;
    logic [7:0] hdr;
    added = 0;
    bpp = cfg_alpha ? 4 : 3;
    while (added < n_bytes) begin
      room = n_bytes - added;
      if ($urandom_range(99) < 15) begin
        // loose bytes that knock the stream out of step
        k = $urandom_range(1, 5);
        repeat (k) byte_queue.push_back(8'($urandom));
        added += k;
      end else begin
        hdr = 8'($urandom);
        if ($urandom_range(19) != 0) hdr[6:0] = 7'($urandom_range(0, 5));
        pix = hdr[7] ? 1 : int'(hdr[6:0]) + 1;
        // keep a long raw packet inside what is left of the phase
        if (!hdr[7] && 1 + pix * bpp > room) begin
          pix = (room > bpp) ? (room - 1) / bpp : 1;
          hdr[6:0] = 7'(pix - 1);
        end
        byte_queue.push_back(hdr);
        repeat (pix * bpp) byte_queue.push_back(8'($urandom));
        added += 1 + pix * bpp;
      end
    end
  endtask

  task automatic run_phase(input logic [31:0] total, input logic has_a,
                           input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned n_bytes, input bit long_hold);
    wait_idle();
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    load_config(total, has_a);
    queue_random_stream(n_bytes);
    if (long_hold) hold_asked++;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // run past the image end, then a raw packet that spills over it
    load_config(32'd2, 1'b0);
    byte_queue = '{8'hFF, 8'h00, 8'hFF, 8'h80,
                   8'h02, 8'h01, 8'h02, 8'h03, 8'h7F, 8'h80, 8'hFF,
                   8'h10, 8'h20, 8'h30};
    // zero total; alpha turned off while a pixel waits for its alpha byte
    wait_idle();
    load_config(32'd0, 1'b1);
    byte_queue = '{8'h00, 8'hAA, 8'h55, 8'hC3};
    wait_idle();
    load_config(32'd0, 1'b0);
    byte_queue.push_back(8'hA5);
    // alpha turned on before the third color byte of a run
    wait_idle();
    byte_queue = '{8'h80, 8'h12, 8'h34};
    wait_idle();
    load_config(32'd2, 1'b1);
    byte_queue = '{8'h56, 8'h78};

    run_phase(32'd37, 1'b0, 0, 0, 150, 1'b0);
    run_phase(32'd1, 1'b1, 85, 0, 150, 1'b0);
    run_phase(32'd4294836225, 1'b0, 0, 85, 150, 1'b0);
    run_phase(32'd0, 1'b1, 10, 10, 100, 1'b0);
    run_phase(32'd200, 1'b0, 0, 0, 200, 1'b1);
    run_phase(32'hFFFF_FFFF, 1'b1, 0, 0, 100, 1'b0);
    run_phase(32'd9, 1'b0, 10, 10, 150, 1'b0);
    run_phase(32'd5, 1'b1, 0, 85, 100, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk);
    if (pix_expect.size() != 0)
      flag_error($sformatf("%0d pixels never came out", pix_expect.size()));
    $display("decoded %0d stream bytes into %0d pixel beats (%0d image ends, %0d overruns)",
             bytes_taken, beats_seen, images_seen, overruns_seen);
    $display("input held back by the decoder on %0d cycles, %0d mismatches",
             held_cycles, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d pixels pending", pix_expect.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
sv/tgarle_pkg.sv
sv/tgarle_core.sv
sv/tgarle_outbuf.sv
sv/tga_rle_pixel_decoder_top.sv
tb/tb_tga_rle_pixel_decoder_top.sv
